### rtl/msh_pkg.sv
`timescale 1ns / 1ps
package msh_pkg;
  localparam int MAX_BINS = 64;
  localparam int BIN_W = $clog2(MAX_BINS);
  localparam logic [2:0] CMD_SAMPLE = 3'd0;
  localparam logic [2:0] CMD_SET_ACTIVE = 3'd1;
  localparam logic [2:0] CMD_READ_ACTIVE = 3'd2;
  localparam logic [2:0] CMD_READ_INTERVAL = 3'd3;
  localparam logic [2:0] CMD_READ_BIN = 3'd4;
  localparam logic [1:0] REG_FUNCTION_MODE = 2'd0;
  localparam logic [1:0] REG_BIN_COUNT = 2'd1;
  localparam logic [1:0] REG_LOWER_LIMIT = 2'd2;
  localparam logic [1:0] REG_UPPER_LIMIT = 2'd3;
  localparam logic [31:0] LOG_SAT = 32'hFF800000;
  localparam logic [31:0] LOG10_OF_2 = 32'h4D104D42;

  typedef struct packed {
    logic [2:0] cmd;
    logic signed [31:0] sample;
    logic [31:0] timestamp;
    logic flag;
    logic [5:0] bin_index;
    logic table_select;
  } in_item_t;

  typedef struct packed {
    logic ok;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic signed [31:0] first_value;
    logic signed [31:0] latest_value;
    logic [31:0] min_time;
    logic [31:0] max_time;
    logic [31:0] first_time;
    logic [31:0] latest_time;
    logic [31:0] start_time;
    logic [31:0] bin_value;
  } out_item_t;
endpackage

### rtl/msh_ram.sv
`timescale 1ns / 1ps
module msh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/measurement_stats_histogram_core.sv
`timescale 1ns / 1ps
// Measurement statistics with histogram.
// in_*: command items (sample, set active, read stats, read bin), valid/ready.
// out_*: one result item per command, valid/ready, held in an output register.
// cfg_*: plain write port; index 0 mode, 1 bin_count, 2 lower, 3 upper limit.
// An item is worked off before in_ready rises again: set active, read stats
// and ignored commands go straight to the output register, read bin first reads
// the tables, and a sample updates the stats and may read and write a bin, an
// interior bin after a 39-step restoring divide on the bin offset. Log10 mode
// adds a leading-one search, 16 squaring steps on the shared 32x32 multiplier,
// then the scale, or only a saturation for a saturated sample. The result goes
// valid at the same edge where in_ready rises again.
// Both histogram tables are memories with a per-table valid-bit row: an entry
// whose valid bit is clear reads as zero, so clearing resets only the flags.
// The row holds 64 flags per table, cleared at once.
// Reset clears control state, config registers, statistics and valid bits. A stalled receiver
// keeps the result unchanged; the block takes one more item, works it off and
// then holds in_ready low until the output register is free.
module measurement_stats_histogram_core
  import msh_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0, S_LOGN = 4'd1, S_LOGSQ = 4'd2,
    S_LOGMUL = 4'd3, S_UPD = 4'd4, S_DIVSET = 4'd5, S_DIV = 4'd6,
    S_RD = 4'd7, S_WR = 4'd8, S_BINRD = 4'd9, S_BINOUT = 4'd10, S_OUT = 4'd11,
    S_RD2 = 4'd12;

  logic [3:0] state;
  in_item_t item;
  out_item_t res;
  logic function_mode;
  logic [6:0] bin_count;
  logic signed [31:0] lower_limit, upper_limit;
  logic active, a_pend, i_pend;
  logic signed [31:0] av [4];
  logic [31:0] at [4];
  logic signed [31:0] iv [4];
  logic [31:0] it [4];
  logic [31:0] istart;
  logic [MAX_BINS-1:0] a_vld, i_vld;

  logic signed [31:0] v;
  logic [31:0] m;
  logic [15:0] frac;
  logic [4:0] cnt;
  logic [5:0] lp;
  logic [BIN_W-1:0] k;
  logic [38:0] num;
  logic [32:0] den, rem;
  logic [6:0] quo;
  logic [5:0] dcnt;
  logic [31:0] a_rd, i_rd;
  logic [31:0] a_wd, i_wd;
  logic mem_we;

  logic [6:0] n;
  assign n = (bin_count > 7'(MAX_BINS)) ? 7'(MAX_BINS) : bin_count;

  logic signed [25:0] l2;
  assign l2 = {10'($signed({1'b0, lp}) - 7'sd16), frac};

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  always_comb begin
    mul_a = m;
    mul_b = m;
    if (state == S_LOGMUL) begin
      mul_a = (l2 < 0) ? 32'(-l2) : 32'(l2);
      mul_b = LOG10_OF_2;
    end
  end
  logic [63:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic [BIN_W-1:0] raddr;
  assign raddr = (state == S_IDLE || state == S_BINRD) ? item.bin_index[BIN_W-1:0] : k;

  msh_ram #(.WIDTH(32), .DEPTH(MAX_BINS)) u_aram (
    .clk, .we(mem_we), .waddr(k), .wdata(a_wd), .raddr(raddr), .rdata(a_rd));
  msh_ram #(.WIDTH(32), .DEPTH(MAX_BINS)) u_iram (
    .clk, .we(mem_we), .waddr(k), .wdata(i_wd), .raddr(raddr), .rdata(i_rd));

  assign mem_we = (state == S_WR);
  assign a_wd = (a_vld[k] ? a_rd : 32'd0) + 32'd1;
  assign i_wd = (i_vld[k] ? i_rd : 32'd0) + 32'd1;
  assign in_ready = (state == S_IDLE);

  logic out_load;
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  logic signed [32:0] dx;
  assign dx = 33'(v) - 33'(lower_limit);
  logic [32:0] rem_sh;
  assign rem_sh = {rem[31:0], num[38]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      function_mode <= 1'b0;
      bin_count <= '0;
      lower_limit <= '0;
      upper_limit <= '0;
      active <= 1'b0;
      a_pend <= 1'b0;
      i_pend <= 1'b0;
      istart <= '0;
      a_vld <= '0;
      i_vld <= '0;
      for (int j = 0; j < 4; j++) begin
        av[j] <= '0; at[j] <= '0; iv[j] <= '0; it[j] <= '0;
      end
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_FUNCTION_MODE: function_mode <= cfg_data[0];
          REG_BIN_COUNT: begin
            bin_count <= cfg_data[6:0];
            a_vld <= '0;
            i_vld <= '0;
          end
          REG_LOWER_LIMIT: lower_limit <= cfg_data;
          REG_UPPER_LIMIT: upper_limit <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (in_valid && in_ready) begin
          item <= in_data;
          res <= '0;
          state <= S_OUT;
          case (in_data.cmd)
            CMD_SAMPLE: if (active) begin
              v <= in_data.sample;
              state <= function_mode ? S_LOGN : S_UPD;
            end
            CMD_SET_ACTIVE: begin
              if (active != in_data.flag) begin
                active <= in_data.flag;
                a_pend <= 1'b1;
                i_pend <= in_data.flag;
                if (in_data.flag) istart <= in_data.timestamp;
              end
              res.ok <= in_data.flag;
            end
            CMD_READ_ACTIVE: if (active && !a_pend) begin
              res <= '{1'b1, av[0], av[1], av[2], av[3],
                at[0], at[1], at[2], at[3], 32'd0, 32'd0};
            end
            CMD_READ_INTERVAL: if (active && !i_pend) begin
              res <= '{1'b1, iv[0], iv[1], iv[2], iv[3],
                it[0], it[1], it[2], it[3], istart, 32'd0};
              if (in_data.flag) begin
                i_pend <= 1'b1;
                istart <= in_data.timestamp;
              end
            end
            CMD_READ_BIN: state <= S_BINRD;
            default: ;
          endcase
        end
        S_LOGN: begin
          if ($signed(v) <= 0) begin
            v <= LOG_SAT;
            state <= S_UPD;
          end else begin
            for (int b = 0; b < 32; b++) if (v[b]) lp <= 6'(b);
            state <= S_RD2;
          end
        end
        S_RD2: begin
          m <= 32'(v) << (5'd31 - lp[4:0]);
          frac <= '0;
          cnt <= '0;
          state <= S_LOGSQ;
        end
        S_LOGSQ: begin
          if (mul_p[63]) begin
            frac <= {frac[14:0], 1'b1};
            m <= mul_p[63:32];
          end else begin
            frac <= {frac[14:0], 1'b0};
            m <= mul_p[62:31];
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd15) state <= S_LOGMUL;
        end
        S_LOGMUL: begin
          v <= (l2 < 0) ? 32'(($signed(-mul_p)) >>> 32) : mul_p[63:32];
          state <= S_UPD;
        end
        S_UPD: begin
          av[3] <= v; at[3] <= item.timestamp;
          iv[3] <= v; it[3] <= item.timestamp;
          if (a_pend) begin
            av[0] <= v; av[1] <= v; av[2] <= v;
            at[0] <= item.timestamp; at[1] <= item.timestamp; at[2] <= item.timestamp;
            a_pend <= 1'b0;
            a_vld <= '0;
          end else begin
            if (v < av[0]) begin av[0] <= v; at[0] <= item.timestamp; end
            if (v > av[1]) begin av[1] <= v; at[1] <= item.timestamp; end
          end
          if (i_pend) begin
            iv[0] <= v; iv[1] <= v; iv[2] <= v;
            it[0] <= item.timestamp; it[1] <= item.timestamp; it[2] <= item.timestamp;
            i_pend <= 1'b0;
            i_vld <= '0;
          end else begin
            if (v < iv[0]) begin iv[0] <= v; it[0] <= item.timestamp; end
            if (v > iv[1]) begin iv[1] <= v; it[1] <= item.timestamp; end
          end
          res.ok <= 1'b1;
          state <= S_OUT;
          if (n != 7'd0) begin
            if (v < lower_limit) begin
              k <= '0;
              state <= S_RD;
            end else if (v >= upper_limit) begin
              if (n > 7'd1) begin
                k <= BIN_W'(n - 7'd1);
                state <= S_RD;
              end
            end else if (n > 7'd2) begin
              state <= S_DIVSET;
            end
          end
        end
        S_DIVSET: begin
          // (n-2)*(x-a) fits 39 bits; divide by (b-a) one bit a cycle
          num <= 39'(dx[31:0] * 39'(n - 7'd2)) | 39'({6'd0, dx[32], 32'd0} * 39'(n - 7'd2));
          den <= 33'(33'(upper_limit) - 33'(lower_limit));
          rem <= '0;
          quo <= '0;
          dcnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          num <= {num[37:0], 1'b0};
          if (rem_sh >= den) begin
            rem <= rem_sh - den;
            quo <= {quo[5:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[5:0], 1'b0};
          end
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd38) begin
            k <= BIN_W'(7'd1 + ((rem_sh >= den) ? {quo[5:0], 1'b1} : {quo[5:0], 1'b0}));
            state <= S_RD;
          end
        end
        S_RD: state <= S_WR;
        S_WR: begin
          a_vld[k] <= 1'b1;
          i_vld[k] <= 1'b1;
          state <= S_OUT;
        end
        S_BINRD: state <= S_BINOUT;
        S_BINOUT: begin
          if ((item.table_select ? (active && !i_pend) : (active && !a_pend))
              && 7'(item.bin_index) < n) begin
            res.ok <= 1'b1;
            res.bin_value <= item.table_select
              ? (i_vld[item.bin_index[BIN_W-1:0]] ? i_rd : 32'd0)
              : (a_vld[item.bin_index[BIN_W-1:0]] ? a_rd : 32'd0);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          // wait here while the previous result is still unclaimed
          if (out_load) begin
            out_data <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");
  assert property (@(posedge clk) disable iff (rst) state == S_WR |=> state == S_OUT)
    else $error("bin write not followed by result");
  assert property (@(posedge clk) disable iff (rst) state == S_OUT |=> out_valid)
    else $error("result lost");
endmodule
